@@ sv/assert_macros.svh @@
// assertion helpers for the basis evaluator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`else
`define CHK_IMPL(label, clk, rst_n, ante, cons)
`define CHK_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ sv/ubsb_pkg.sv @@
`timescale 1ns / 1ps
package ubsb_pkg;
    localparam int DEF_MAX_DEGREE = 3;
    localparam int DEF_MAX_KNOTS = 256;
    localparam int DEF_FRAC_BITS = 16;
    localparam int IDX_W = 9;
    localparam int DEG_W = 3;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FIRST_KNOT = 2'd0,
        REG_INV_SPACING = 2'd1,
        REG_NUM_KNOTS = 2'd2,
        REG_SPLINE_DEGREE = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        OP_BASIS = 1'b0,
        OP_DERIV = 1'b1
    } op_t;

    typedef struct packed {
        logic [31:0] first_knot;
        logic [31:0] inv_spacing;
        logic [IDX_W-1:0] num_knots;
        logic [DEG_W-1:0] spline_degree;
    } cfg_t;
endpackage

@@ sv/ubsb_stream_if.sv @@
`timescale 1ns / 1ps
interface ubsb_stream_if #(parameter int W = 33);
    logic valid;
    logic ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ sv/ubsb_locate.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
// interval search: 3 stages (sub, multiply, clamp)
module ubsb_locate
    import ubsb_pkg::*;
#(
    parameter int MAX_DEGREE = DEF_MAX_DEGREE,
    parameter int MAX_KNOTS = DEF_MAX_KNOTS,
    parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  logic in_op,
    input  logic [31:0] in_sample,
    input  cfg_t cfg,
    output logic out_valid,
    output logic out_op,
    output logic out_oor,
    output logic [DEG_W-1:0] out_deg,
    output logic [IDX_W-1:0] out_j,
    output logic [FRAC_BITS:0] out_u
);
    localparam int KW = $clog2(MAX_KNOTS + 1);
    localparam int TW = 66;
    localparam logic [FRAC_BITS:0] ONE_U = {1'b1, {FRAC_BITS{1'b0}}};

    logic [DEG_W-1:0] deg_sat;
    logic [KW-1:0] nk_sat;
    logic [32:0] diff;
    logic [32:0] mag;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic s1_op_reg, s2_op_reg, s3_op_reg;
    logic s1_neg_reg, s2_neg_reg;
    logic [31:0] s1_ml_reg;
    logic s1_mh_reg;
    logic [63:0] s2_lo_reg;
    logic s2_mh_reg;
    logic s3_oor_reg;
    logic [DEG_W-1:0] s3_deg_reg;
    logic [IDX_W-1:0] s3_j_reg;
    logic [FRAC_BITS:0] s3_u_reg;

    logic signed [TW-1:0] fl, t, lo_b, hi_b, tc;
    logic oor_c;
    logic [TW-1:0] jj;
    logic [TW-1:0] jfix;
    logic [TW-1:0] uu;

    always_comb
    begin
        if (cfg.spline_degree == '0)
            deg_sat = DEG_W'(1);
        else if (int'(cfg.spline_degree) > MAX_DEGREE)
            deg_sat = DEG_W'(MAX_DEGREE);
        else
            deg_sat = cfg.spline_degree;
        if (cfg.num_knots < IDX_W'(2))
            nk_sat = KW'(2);
        else if (int'(cfg.num_knots) > MAX_KNOTS)
            nk_sat = KW'(MAX_KNOTS);
        else
            nk_sat = KW'(cfg.num_knots);
    end

    assign diff = {in_sample[31], in_sample} - {cfg.first_knot[31], cfg.first_knot};
    assign mag = diff[32] ? (~diff + 33'd1) : diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_op_reg <= in_op;
            s1_neg_reg <= diff[32];
            s1_ml_reg <= mag[31:0];
            s1_mh_reg <= mag[32];
            s2_op_reg <= s1_op_reg;
            s2_neg_reg <= s1_neg_reg;
            s2_lo_reg <= 64'(s1_ml_reg) * 64'(cfg.inv_spacing);
            s2_mh_reg <= s1_mh_reg;
            s3_op_reg <= s2_op_reg;
            s3_oor_reg <= oor_c;
            s3_deg_reg <= deg_sat;
            s3_j_reg <= jfix[IDX_W-1:0];
            s3_u_reg <= uu[FRAC_BITS:0];
        end
    end

    always_comb
    begin
        fl = TW'(s2_lo_reg >> FRAC_BITS);
        if (s2_mh_reg)
            fl = fl + (TW'(cfg.inv_spacing) << (32 - FRAC_BITS));
        if (s2_neg_reg)
        begin
            if (s2_lo_reg[FRAC_BITS-1:0] != '0)
                fl = fl + TW'(1);
            t = -fl;
        end
        else
            t = fl;
        lo_b = TW'(deg_sat) << FRAC_BITS;
        hi_b = (TW'(deg_sat) + TW'(nk_sat) - TW'(1)) << FRAC_BITS;
        tc = t;
        oor_c = 1'b0;
        if (t < lo_b)
        begin
            tc = lo_b;
            oor_c = 1'b1;
        end
        if (t > hi_b)
        begin
            tc = hi_b;
            oor_c = 1'b1;
        end
        jj = (TW'(tc) >> FRAC_BITS) - TW'(deg_sat);
        jfix = (jj > TW'(nk_sat) - TW'(2)) ? TW'(nk_sat) - TW'(2) : jj;
        uu = TW'(tc) - ((jfix + TW'(deg_sat)) << FRAC_BITS);
    end

    assign out_valid = s3_valid_reg;
    assign out_op = s3_op_reg;
    assign out_oor = s3_oor_reg;
    assign out_deg = s3_deg_reg;
    assign out_j = s3_j_reg;
    assign out_u = s3_u_reg;

    `CHK_IMPL(a_u_le_one, clk, rst_n, s3_valid_reg, s3_u_reg <= ONE_U)
    `CHK_IMPL(a_deg_ok, clk, rst_n, s3_valid_reg, s3_deg_reg != '0)
    `CHK_NEXT(a_hold, clk, rst_n, !en, $stable(s3_valid_reg))
endmodule

@@ sv/ubsb_level.sv @@
`timescale 1ns / 1ps
// one recursion level, two register stages (multiply, divide)
module ubsb_level
    import ubsb_pkg::*;
#(
    parameter int MAX_DEGREE = DEF_MAX_DEGREE,
    parameter int FRAC_BITS = DEF_FRAC_BITS,
    parameter int L = 1
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  logic in_op,
    input  logic in_oor,
    input  logic [DEG_W-1:0] in_deg,
    input  logic [IDX_W-1:0] in_j,
    input  logic [FRAC_BITS:0] in_u,
    input  logic [MAX_DEGREE:0][FRAC_BITS:0] in_n,
    output logic out_valid,
    output logic out_op,
    output logic out_oor,
    output logic [DEG_W-1:0] out_deg,
    output logic [IDX_W-1:0] out_j,
    output logic [FRAC_BITS:0] out_u,
    output logic [MAX_DEGREE:0][FRAC_BITS:0] out_n
);
    localparam int PW = 2 * FRAC_BITS + 8;
    localparam int QW = FRAC_BITS + 1;
    localparam int ZW = FRAC_BITS + 4;
    localparam int SH = ZW + 3;
    localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);
    localparam logic [PW-1:0] BIAS = PW'(L) * HALF;
    localparam logic [ZW-1:0] ONE_Z = ZW'(1) << FRAC_BITS;
    // ceil(2^SH / L), exact floor quotient for any ZW-bit dividend
    localparam logic [SH:0] RECIP = (SH+1)'(((64'd1 << SH) + 64'(L) - 64'd1) / 64'(L));

    logic act;
    logic a_valid_reg, b_valid_reg;
    logic a_op_reg, b_op_reg, a_oor_reg, b_oor_reg, a_act_reg;
    logic [DEG_W-1:0] a_deg_reg, b_deg_reg;
    logic [IDX_W-1:0] a_j_reg, b_j_reg;
    logic [FRAC_BITS:0] a_u_reg, b_u_reg;
    logic [MAX_DEGREE:0][FRAC_BITS:0] a_n_reg, b_n_reg;
    logic [L:0][PW-1:0] acc_reg;
    logic [L:0][PW-1:0] acc_next;
    logic [MAX_DEGREE:0][FRAC_BITS:0] n_next;
    logic [L:0][ZW-1:0] z;
    logic [L:0][ZW+SH:0] qp;
    logic [L:0][ZW-1:0] q;

    assign act = (in_op == OP_DERIV) ? (int'(in_deg) - 1 >= L) : (int'(in_deg) >= L);

    always_comb
    begin
        for (int m = 0; m <= L; m++)
        begin
            acc_next[m] = '0;
            if (m < L)
                acc_next[m] = acc_next[m]
                    + ((PW'(m) << FRAC_BITS) + PW'(in_u)) * PW'(in_n[m]);
            if (m >= 1)
                acc_next[m] = acc_next[m]
                    + ((PW'(L + 1 - m) << FRAC_BITS) - PW'(in_u)) * PW'(in_n[m-1]);
        end
    end

    // round(acc / L) in Q, as floor((acc + L*half) / 2^frac) / L
    always_comb
    begin
        n_next = a_n_reg;
        for (int m = 0; m <= L; m++)
        begin
            z[m] = ZW'((acc_reg[m] + BIAS) >> FRAC_BITS);
            qp[m] = (ZW+SH+1)'(z[m]) * (ZW+SH+1)'(RECIP);
            q[m] = ZW'(qp[m] >> SH);
            if (a_act_reg)
                n_next[m] = (q[m] > ONE_Z) ? QW'(ONE_Z) : QW'(q[m]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_op_reg <= in_op;
            a_oor_reg <= in_oor;
            a_deg_reg <= in_deg;
            a_j_reg <= in_j;
            a_u_reg <= in_u;
            a_n_reg <= in_n;
            a_act_reg <= act;
            acc_reg <= acc_next;
            b_op_reg <= a_op_reg;
            b_oor_reg <= a_oor_reg;
            b_deg_reg <= a_deg_reg;
            b_j_reg <= a_j_reg;
            b_u_reg <= a_u_reg;
            b_n_reg <= n_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_op = b_op_reg;
    assign out_oor = b_oor_reg;
    assign out_deg = b_deg_reg;
    assign out_j = b_j_reg;
    assign out_u = b_u_reg;
    assign out_n = b_n_reg;
endmodule

@@ sv/ubsb_emit.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
// final stage: holds one item, emits degree+1 results one per cycle while res.ready is high
module ubsb_emit
    import ubsb_pkg::*;
#(
    parameter int MAX_DEGREE = DEF_MAX_DEGREE,
    parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic in_op,
    input  logic in_oor,
    input  logic [DEG_W-1:0] in_deg,
    input  logic [IDX_W-1:0] in_j,
    input  logic [MAX_DEGREE:0][FRAC_BITS:0] in_n,
    input  logic [31:0] inv_spacing,
    ubsb_stream_if.source res
);
    localparam int QW = FRAC_BITS + 1;
    localparam int NW = $clog2(MAX_DEGREE + 1);
    localparam logic [63:0] HALF = 64'(1) << (FRAC_BITS - 1);

    logic full_reg;
    logic [DEG_W-1:0] k_reg;
    logic op_reg, oor_reg;
    logic [DEG_W-1:0] deg_reg;
    logic [IDX_W-1:0] j_reg;
    logic [MAX_DEGREE:0][FRAC_BITS:0] n_reg;
    logic [DEG_W-1:0] m;
    logic [FRAC_BITS:0] pa, pb;
    logic signed [QW+1:0] dv;
    logic [QW-1:0] dmag;
    logic [63:0] pm, r;
    logic [31:0] val;
    logic is_last;
    logic fire;

    assign m = deg_reg - k_reg;
    assign is_last = (k_reg == deg_reg);
    assign fire = full_reg && res.ready;
    assign in_ready = !full_reg || (fire && is_last);

    always_comb
    begin
        pa = (m < deg_reg) ? n_reg[NW'(m)] : '0;
        pb = (m >= DEG_W'(1)) ? n_reg[NW'(m - DEG_W'(1))] : '0;
        dv = $signed({2'b00, pa}) - $signed({2'b00, pb});
        dmag = dv[QW+1] ? QW'(-dv) : QW'(dv);
        pm = 64'(dmag) * 64'(inv_spacing);
        r = (pm + HALF) >> FRAC_BITS;
        if (op_reg == OP_DERIV)
        begin
            if (r > 64'h7FFF_FFFF)
                val = dv[QW+1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            else
                val = dv[QW+1] ? 32'(-r) : r[31:0];
        end
        else
            val = 32'(n_reg[NW'(m)]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
            k_reg <= '0;
        end
        else if (in_ready && in_valid)
        begin
            full_reg <= 1'b1;
            k_reg <= '0;
        end
        else if (fire)
        begin
            if (is_last)
                full_reg <= 1'b0;
            k_reg <= k_reg + DEG_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            op_reg <= in_op;
            oor_reg <= in_oor;
            deg_reg <= in_deg;
            j_reg <= in_j;
            n_reg <= in_n;
        end
    end

    assign res.valid = full_reg;
    assign res.data = {IDX_W'(j_reg + IDX_W'(k_reg)), val, oor_reg, is_last};

    `CHK_IMPL(a_k_bound, clk, rst_n, full_reg, k_reg <= deg_reg)
    `CHK_NEXT(a_last_empties, clk, rst_n, fire && is_last && !in_valid, !full_reg)
    `CHK_NEXT(a_step, clk, rst_n, fire && !is_last, full_reg && k_reg == $past(k_reg) + 3'd1)
endmodule

@@ sv/uniform_bspline_basis_eval_unit.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
// channel | dir | payload (msb..lsb)
// req     | in  | operation, sample[31:0]
// res     | out | basis_index[8:0], basis_value[31:0], out_of_range, last
// an item enters every cycle while the pipe moves; 3 locate stages, 2 stages per
// recursion level and the result register lie between a request and its first
// result
// the result stage sends degree+1 results, one per cycle while res.ready is high,
// and takes the next item only as it sends the last result of the current one
// rst_n clears all valid bits and the result counter; config resets to defaults
// a stall at the result stage freezes the whole pipe once a valid item waits at its input, nothing is lost
module uniform_bspline_basis_eval_unit
    import ubsb_pkg::*;
#(
    parameter int MAX_DEGREE = DEF_MAX_DEGREE,
    parameter int MAX_KNOTS = DEF_MAX_KNOTS,
    parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [CFG_IDX_W:0] cfg_index,
    input  logic [31:0] cfg_data,
    ubsb_stream_if.sink req,
    ubsb_stream_if.source res
);
    localparam logic [FRAC_BITS:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};
    localparam int NVW = (MAX_DEGREE + 1) * (FRAC_BITS + 1);

    cfg_t cfg_reg;
    logic en;
    logic emit_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.first_knot <= '0;
            cfg_reg.inv_spacing <= 32'h0001_0000;
            cfg_reg.num_knots <= IDX_W'(20);
            cfg_reg.spline_degree <= DEG_W'(3);
        end
        else if (cfg_we && !cfg_index[CFG_IDX_W])
        begin
            case (cfg_reg_t'(cfg_index[CFG_IDX_W-1:0]))
                REG_FIRST_KNOT: cfg_reg.first_knot <= cfg_data;
                REG_INV_SPACING: cfg_reg.inv_spacing <= cfg_data;
                REG_NUM_KNOTS: cfg_reg.num_knots <= cfg_data[IDX_W-1:0];
                REG_SPLINE_DEGREE: cfg_reg.spline_degree <= cfg_data[DEG_W-1:0];
                default: ;
            endcase
        end
    end

    logic [MAX_DEGREE:0] v_s;
    logic [MAX_DEGREE:0] op_s, oor_s;
    logic [MAX_DEGREE:0][DEG_W-1:0] deg_s;
    logic [MAX_DEGREE:0][IDX_W-1:0] j_s;
    logic [MAX_DEGREE:0][FRAC_BITS:0] u_s;
    logic [MAX_DEGREE:0][MAX_DEGREE:0][FRAC_BITS:0] n_s;

    assign en = emit_ready || !v_s[MAX_DEGREE];
    assign req.ready = en;

    ubsb_locate #(
        .MAX_DEGREE(MAX_DEGREE), .MAX_KNOTS(MAX_KNOTS), .FRAC_BITS(FRAC_BITS)
    ) u_locate (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(req.valid), .in_op(req.data[32]), .in_sample(req.data[31:0]),
        .cfg(cfg_reg),
        .out_valid(v_s[0]), .out_op(op_s[0]), .out_oor(oor_s[0]),
        .out_deg(deg_s[0]), .out_j(j_s[0]), .out_u(u_s[0])
    );

    assign n_s[0] = NVW'(ONE_Q);

    for (genvar g = 1; g <= MAX_DEGREE; g++)
    begin : g_lvl
        ubsb_level #(.MAX_DEGREE(MAX_DEGREE), .FRAC_BITS(FRAC_BITS), .L(g)) u_level (
            .clk(clk), .rst_n(rst_n), .en(en),
            .in_valid(v_s[g-1]), .in_op(op_s[g-1]), .in_oor(oor_s[g-1]),
            .in_deg(deg_s[g-1]), .in_j(j_s[g-1]), .in_u(u_s[g-1]), .in_n(n_s[g-1]),
            .out_valid(v_s[g]), .out_op(op_s[g]), .out_oor(oor_s[g]),
            .out_deg(deg_s[g]), .out_j(j_s[g]), .out_u(u_s[g]), .out_n(n_s[g])
        );
    end

    ubsb_emit #(.MAX_DEGREE(MAX_DEGREE), .FRAC_BITS(FRAC_BITS)) u_emit (
        .clk(clk), .rst_n(rst_n),
        .in_valid(v_s[MAX_DEGREE]), .in_ready(emit_ready),
        .in_op(op_s[MAX_DEGREE]), .in_oor(oor_s[MAX_DEGREE]),
        .in_deg(deg_s[MAX_DEGREE]), .in_j(j_s[MAX_DEGREE]), .in_n(n_s[MAX_DEGREE]),
        .inv_spacing(cfg_reg.inv_spacing),
        .res(res)
    );

    `CHK_IMPL(a_req_moves, clk, rst_n, v_s[MAX_DEGREE] && !emit_ready, !req.ready)
    `CHK_NEXT(a_cfg_deg, clk, rst_n, cfg_we && cfg_index == {1'b0, REG_SPLINE_DEGREE},
              cfg_reg.spline_degree == $past(cfg_data[DEG_W-1:0]))
    `CHK_IMPL(a_last_valid, clk, rst_n, res.valid && res.data[0], res.valid)
endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
    import ubsb_pkg::*;

    localparam int PIPE_LAT = 3 + 2 * DEF_MAX_DEGREE + 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [CFG_IDX_W:0] UNUSED_REG = 3'd5;
    localparam longint unsigned ONE = 64'd1 << DEF_FRAC_BITS;
    localparam longint unsigned HALF = 64'd1 << (DEF_FRAC_BITS - 1);

    typedef struct {
        logic [IDX_W-1:0] idx;
        logic [31:0] val;
        logic oor;
        logic last;
    } basis_result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W:0] cfg_index;
    logic [31:0] cfg_data;

    ubsb_stream_if #(.W(33)) req_if ();
    ubsb_stream_if #(.W(43)) res_if ();

    uniform_bspline_basis_eval_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .req(req_if),
        .res(res_if)
    );

    // shadow copy of the configuration
    logic [31:0] knot0;
    logic [31:0] inv_h;
    logic [IDX_W-1:0] knot_cnt;
    logic [DEG_W-1:0] degree;

    basis_result_t pending_basis[$];
    int errors = 0;
    int cycles = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge clk)
        res_if.ready <= ($urandom_range(99) >= stall_pct);

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        basis_result_t got;
        basis_result_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            {got.idx, got.val, got.oor, got.last} = res_if.data;
            if (pending_basis.size() == 0)
                report("unexpected result", 64'(res_if.data), 64'd0);
            else
            begin
                want = pending_basis.pop_front();
                if (got.idx !== want.idx) report("basis_index", 64'(got.idx), 64'(want.idx));
                if (got.val !== want.val) report("basis_value", 64'(got.val), 64'(want.val));
                if (got.oor !== want.oor) report("out_of_range", 64'(got.oor), 64'(want.oor));
                if (got.last !== want.last) report("last", 64'(got.last), 64'(want.last));
            end
        end
    end

    function automatic longint sat_word(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // cox-de boor evaluation on equidistant knots
    task automatic predict_basis(input op_t op, input logic [31:0] x);
        int unsigned d, nk, lim, m;
        longint diff, t, lo_b, hi_b, dv, r, v;
        longint unsigned mag, lo, fl, u, j, acc, nv, pm;
        longint unsigned prev[0:DEF_MAX_DEGREE+1];
        longint unsigned cur[0:DEF_MAX_DEGREE+1];
        logic oor;
        basis_result_t e;
        d = degree;
        if (d < 1) d = 1;
        if (d > DEF_MAX_DEGREE) d = DEF_MAX_DEGREE;
        nk = knot_cnt;
        if (nk < 2) nk = 2;
        if (nk > DEF_MAX_KNOTS) nk = DEF_MAX_KNOTS;
        diff = longint'($signed(x)) - longint'($signed(knot0));
        mag = diff < 0 ? longint'(-diff) : diff;
        lo = mag[31:0] * longint'(inv_h);
        fl = ((mag >> 32) != 0 ? (longint'(inv_h) << (32 - DEF_FRAC_BITS)) : 0)
             + (lo >> DEF_FRAC_BITS);
        if (diff < 0)
        begin
            if ((lo & (ONE - 1)) != 0) fl += 1;
            t = -longint'(fl);
        end
        else
            t = fl;
        oor = 1'b0;
        lo_b = longint'(d) * ONE;
        hi_b = longint'(d + nk - 1) * ONE;
        if (t < lo_b) begin t = lo_b; oor = 1'b1; end
        if (t > hi_b) begin t = hi_b; oor = 1'b1; end
        j = (longint'(t) >>> DEF_FRAC_BITS) - d;
        if (j > nk - 2) j = nk - 2;
        u = t - ((j + d) << DEF_FRAC_BITS);
        prev[0] = ONE;
        lim = (op == OP_DERIV) ? d - 1 : d;
        for (int unsigned l = 1; l <= lim; l++)
        begin
            for (m = 0; m <= l; m++)
            begin
                acc = 0;
                if (m < l) acc += ((longint'(m) << DEF_FRAC_BITS) + u) * prev[m];
                if (m >= 1) acc += ((longint'(l + 1 - m) << DEF_FRAC_BITS) - u) * prev[m-1];
                nv = (acc / l + HALF) >> DEF_FRAC_BITS;
                cur[m] = nv > ONE ? ONE : nv;
            end
            for (m = 0; m <= l; m++) prev[m] = cur[m];
        end
        for (int unsigned k = 0; k <= d; k++)
        begin
            m = d - k;
            if (op == OP_DERIV)
            begin
                dv = 0;
                if (m < d) dv += longint'(prev[m]);
                if (m >= 1) dv -= longint'(prev[m-1]);
                pm = (dv < 0 ? longint'(-dv) : dv) * longint'(inv_h);
                r = longint'((pm + HALF) >> DEF_FRAC_BITS);
                v = sat_word(dv < 0 ? -r : r);
            end
            else
                v = sat_word(longint'(prev[m]));
            e.idx = IDX_W'(j + k);
            e.val = v[31:0];
            e.oor = oor;
            e.last = (k == d);
            pending_basis = {pending_basis, e};
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W:0] idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            {1'b0, REG_FIRST_KNOT}: knot0 = val;
            {1'b0, REG_INV_SPACING}: inv_h = val;
            {1'b0, REG_NUM_KNOTS}: knot_cnt = val[IDX_W-1:0];
            {1'b0, REG_SPLINE_DEGREE}: degree = val[DEG_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_config(input logic [31:0] fk, input logic [31:0] inv,
                              input logic [31:0] nk, input logic [31:0] deg);
        write_reg({1'b0, REG_FIRST_KNOT}, fk);
        write_reg({1'b0, REG_INV_SPACING}, inv);
        write_reg({1'b0, REG_NUM_KNOTS}, nk);
        write_reg({1'b0, REG_SPLINE_DEGREE}, deg);
    endtask

    task automatic send_sample(input op_t op, input logic [31:0] x);
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.data <= {op, x};
        do
            @(posedge clk);
        while (!req_if.ready);
        predict_basis(op, x);
    endtask

    task automatic drain;
        req_if.valid <= 1'b0;
        while (pending_basis.size() != 0) @(posedge clk);
        repeat (PIPE_LAT) @(posedge clk);
    endtask

    // sample placed inside or just around the knot range, or fully random
    function automatic logic [31:0] pick_sample();
        longint unsigned span, tq;
        if (inv_h == 0 || $urandom_range(3) == 0) return $urandom;
        span = (longint'(degree) + longint'(knot_cnt) + 1) * ONE;
        if (span > 64'd600 * ONE) span = 64'd600 * ONE;
        tq = ($urandom_range(7) == 0) ? (longint'($urandom_range(0, 600)) << 16)
                                       : longint'($urandom) % span;
        return knot0 + 32'((tq << DEF_FRAC_BITS) / inv_h);
    endfunction

    task automatic test_defaults;
        send_sample(OP_BASIS, 32'h0000_0000);
        send_sample(OP_DERIV, 32'h0000_0000);
        send_sample(OP_BASIS, 32'h8000_0000);
        send_sample(OP_DERIV, 32'h7FFF_FFFF);
        send_sample(OP_BASIS, 32'd22 << 16);
        send_sample(OP_DERIV, 32'd22 << 16);
        send_sample(OP_BASIS, 32'h0004_8000);
        send_sample(OP_DERIV, 32'h000A_4321);
        send_sample(OP_BASIS, 32'hFFFF_FFFF);
        drain();
    endtask

    task automatic test_register_extremes;
        set_config(32'h8000_0000, 32'hFFFF_FFFF, 32'd2, 32'd1);
        send_sample(OP_BASIS, 32'h8000_0000);
        send_sample(OP_DERIV, 32'h8000_8000);
        send_sample(OP_DERIV, 32'h7FFF_FFFF);
        drain();
        set_config(32'h7FFF_FFFF, 32'd1, 32'd0, 32'd0);
        send_sample(OP_BASIS, 32'h8000_0000);
        send_sample(OP_DERIV, 32'h7FFF_FFFF);
        drain();
        set_config(32'h0000_0000, 32'd0, 32'd511, 32'd7);
        send_sample(OP_BASIS, 32'h1234_5678);
        send_sample(OP_DERIV, 32'hFFFF_0000);
        drain();
        set_config(32'hFFFF_0000, 32'h0002_0000, 32'd256, 32'd2);
        write_reg(UNUSED_REG, 32'hDEAD_BEEF);
        send_sample(OP_BASIS, 32'h0040_0000);
        send_sample(OP_DERIV, 32'h0081_7FFF);
        send_sample(OP_BASIS, 32'h0000_0000);
        drain();
    endtask

    task automatic test_random_phase(input int n_items, input int idle_pct, input int stl_pct);
        logic [31:0] inv;
        case ($urandom_range(3))
            0: inv = 32'h0001_0000;
            1: inv = 32'h0000_4000;
            2: inv = 32'h0010_0000;
            default: inv = $urandom_range(1, 32'h0100_0000);
        endcase
        set_config($urandom, inv, ($urandom_range(9) == 0) ? 32'd511 : $urandom_range(0, 40),
                   $urandom_range(0, 7));
        send_idle_pct = idle_pct;
        stall_pct = stl_pct;
        for (int i = 0; i < n_items; i++)
            send_sample(op_t'($urandom_range(1)), pick_sample());
        drain();
        send_idle_pct = 0;
        stall_pct = 0;
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        req_if.valid <= 1'b0;
        req_if.data <= '0;
        knot0 = 32'd0;
        inv_h = 32'h0001_0000;
        knot_cnt = 9'd20;
        degree = 3'd3;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_defaults();
        test_register_extremes();
        for (int p = 0; p < 2; p++)
        begin
            test_random_phase(55, 0, 0);
            test_random_phase(55, 57, 0);
            test_random_phase(55, 0, 57);
            test_random_phase(55, 9, 9);
        end
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

@@ uniform_bspline_basis_eval_unit.f @@
+incdir+sv
sv/ubsb_pkg.sv
sv/ubsb_stream_if.sv
sv/ubsb_locate.sv
sv/ubsb_level.sv
sv/ubsb_emit.sv
sv/uniform_bspline_basis_eval_unit.sv
verif/testbench.sv
